@@ hdl/hcbp_pkg.sv @@
// Shared types, constants and helpers for the Huffman code bit packer.
`default_nettype none
package hcbp_pkg;

    // Operation codes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    // Field widths of a transaction
    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 5;
    localparam int CODE_W  = 26;
    localparam int LEN_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int TOTAL_W = 32;

    // Longest code word the table keeps
    localparam logic [LEN_W-1:0] MAX_CODE_LEN = 5'd26;

    // Bit accumulator: up to 7 held bits plus one full code word
    localparam int PEND_W  = 7;
    localparam int CNT_W   = 3;
    localparam int ACC_W   = PEND_W + CODE_W;
    localparam int ACNT_W  = 6;
    // Left-aligned window holding every byte one encode can complete
    localparam int OB_DEPTH = 4;
    localparam int ALIGN_W  = BYTE_W * (OB_DEPTH + 1);
    localparam int OBC_W    = 3;

    // Table entry as stored in memory
    localparam int ENTRY_W = LEN_W + CODE_W;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'd65;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'd90;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'd97;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'd122;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'd32;
    localparam logic [CHAR_W-1:0] LETTER_BASE  = 8'd64;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] sym;
    } t_sym;

    // Map a raw character to its symbol; space is 0, letters A..Z are 1..26
    function automatic t_sym char_to_sym(input logic [CHAR_W-1:0] c);
        t_sym             r;
        logic [CHAR_W-1:0] u;
        logic [CHAR_W-1:0] d;
        r.ok  = 1'b0;
        r.sym = '0;
        u     = c;
        if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
            u = c - CASE_OFFSET;
        end
        d = u - LETTER_BASE;
        if (c == CHAR_SPACE) begin
            r.ok  = 1'b1;
            r.sym = '0;
        end else if (u inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            r.ok  = 1'b1;
            r.sym = d[IDX_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hdl/huffman_code_bit_packer_unit.sv @@
// Huffman code bit packer: code table RAM, bit accumulator and output byte queue.
// A transaction is registered into stage 1, and its results are then registered into the output queue.
// Throughput: one transaction per cycle while each yields at most one result and the output is not
//   stalled; an encode that completes n bytes (up to 4) sends them one at a time on the one-byte port.
// Loads write the table RAM at acceptance, so a following encode sees the new entry.
// Reset (synchronous) clears the table valid bits, accumulator and queue.
`default_nettype none
module huffman_code_bit_packer_unit
    import hcbp_pkg::*;
#(
    parameter int ALPHABET_SIZE = 27
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Input channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [OP_W-1:0]    i_operation,
    input  wire logic [CHAR_W-1:0]  i_char_code,
    input  wire logic [IDX_W-1:0]   i_table_index,
    input  wire logic [CODE_W-1:0]  i_code_bits,
    input  wire logic [LEN_W-1:0]   i_code_length,
    // Output channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [BYTE_W-1:0]       o_out_byte,
    output logic                    o_byte_valid,
    output logic                    o_is_last,
    output logic [TOTAL_W-1:0]      o_total_bits
);

    localparam int ADDR_W = $clog2(ALPHABET_SIZE);

    // Stage 0: decode the incoming transaction
    logic               in_acc;
    logic               out_acc;
    t_sym               sym;
    logic               sym_ok;
    logic               idx_ok;
    logic [LEN_W-1:0]   ld_len;
    logic [CODE_W-1:0]  ld_code;
    logic               tbl_we;
    logic               tbl_re;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  raddr;
    logic [ENTRY_W-1:0] rdata;

    logic               r_tbl_vld [ALPHABET_SIZE];

    // Stage 1 registers
    logic               r_s1_valid;
    logic               r_s1_flush;
    logic               r_s1_ent_vld;
    logic [PEND_W-1:0]  r_pend_bits;
    logic [CNT_W-1:0]   r_pend_cnt;
    logic [TOTAL_W-1:0] r_bit_total;

    // Output queue
    logic [BYTE_W-1:0]  r_ob_byte [OB_DEPTH];
    logic [OBC_W-1:0]   r_ob_cnt;
    logic               r_ob_bvalid;
    logic               r_ob_last;
    logic [TOTAL_W-1:0] r_ob_total;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    assign sym     = char_to_sym(i_char_code);
    assign sym_ok  = sym.ok && (32'(sym.sym) < ALPHABET_SIZE);
    assign idx_ok  = 32'(i_table_index) < ALPHABET_SIZE;

    // Load entry: clamp the length and drop bits above it
    assign ld_len  = (i_code_length > MAX_CODE_LEN) ? MAX_CODE_LEN : i_code_length;
    assign ld_code = i_code_bits & ~({CODE_W{1'b1}} << ld_len);

    assign tbl_we  = in_acc && (i_operation == OP_LOAD) && idx_ok;
    assign tbl_re  = in_acc && (i_operation == OP_ENCODE) && sym_ok;
    assign waddr   = ADDR_W'(i_table_index);
    assign raddr   = ADDR_W'(sym.sym);

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (waddr),
        .i_wdata ({ld_len, ld_code}),
        .i_re    (tbl_re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Table valid bits: an entry never loaded reads as length zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ALPHABET_SIZE; k++) begin
                r_tbl_vld[k] <= 1'b0;
            end
        end else if (tbl_we) begin
            r_tbl_vld[waddr] <= 1'b1;
        end
    end

    // Stage 1: append the code word to the accumulator
    logic [LEN_W-1:0]   s1_len;
    logic [CODE_W-1:0]  s1_code;
    logic [ACC_W-1:0]   acc;
    logic [ACNT_W-1:0]  acnt;
    logic [ALIGN_W-1:0] aligned;
    logic [OBC_W-1:0]   s1_nres;
    logic               ob_free;
    logic               s1_adv;
    logic [PEND_W-1:0]  n_pend_bits;
    logic [BYTE_W-1:0]  flush_byte;

    assign s1_len   = r_s1_ent_vld ? rdata[ENTRY_W-1 -: LEN_W] : '0;
    assign s1_code  = r_s1_ent_vld ? rdata[CODE_W-1:0] : '0;
    assign acc      = (ACC_W'(r_pend_bits) << s1_len) | ACC_W'(s1_code);
    assign acnt     = ACNT_W'(r_pend_cnt) + ACNT_W'(s1_len);
    assign aligned  = ALIGN_W'(acc) << (ACNT_W'(ALIGN_W) - acnt);
    assign n_pend_bits = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << acnt[CNT_W-1:0]);
    assign flush_byte  = (r_pend_cnt == '0) ? '0
                       : BYTE_W'({1'b0, r_pend_bits} << (4'd8 - {1'b0, r_pend_cnt}));

    assign s1_nres  = r_s1_flush ? OBC_W'(1) : acnt[ACNT_W-1:CNT_W];
    assign ob_free  = (r_ob_cnt == '0) || ((r_ob_cnt == OBC_W'(1)) && out_acc);
    assign s1_adv   = r_s1_valid && ((s1_nres == '0) || ob_free);
    assign o_stall  = r_s1_valid && !s1_adv;

    // Stage 1 occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= tbl_re || (i_operation == OP_FLUSH);
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_flush <= (i_operation == OP_FLUSH);
        end
        if (tbl_re) begin
            r_s1_ent_vld <= r_tbl_vld[raddr];
        end
    end

    // Accumulator and bit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_bit_total <= '0;
        end else if (s1_adv) begin
            if (r_s1_flush) begin
                r_pend_bits <= '0;
                r_pend_cnt  <= '0;
                r_bit_total <= '0;
            end else begin
                r_pend_bits <= n_pend_bits;
                r_pend_cnt  <= acnt[CNT_W-1:0];
                r_bit_total <= r_bit_total + TOTAL_W'(s1_len);
            end
        end
    end

    // Output queue: loaded from stage 1, shifted one byte per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_cnt <= '0;
        end else if (s1_adv && (s1_nres != '0)) begin
            r_ob_cnt <= s1_nres;
        end else if (out_acc) begin
            r_ob_cnt <= r_ob_cnt - OBC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && (s1_nres != '0)) begin
            if (r_s1_flush) begin
                r_ob_byte[0] <= flush_byte;
                r_ob_bvalid  <= (r_pend_cnt != '0);
                r_ob_last    <= 1'b1;
                r_ob_total   <= r_bit_total;
            end else begin
                for (int k = 0; k < OB_DEPTH; k++) begin
                    r_ob_byte[k] <= aligned[ALIGN_W-1-BYTE_W*k -: BYTE_W];
                end
                r_ob_bvalid <= 1'b1;
                r_ob_last   <= 1'b0;
                r_ob_total  <= '0;
            end
        end else if (out_acc) begin
            for (int k = 0; k < OB_DEPTH - 1; k++) begin
                r_ob_byte[k] <= r_ob_byte[k+1];
            end
        end
    end

    assign o_valid      = (r_ob_cnt != '0);
    assign o_out_byte   = r_ob_byte[0];
    assign o_byte_valid = r_ob_bvalid;
    assign o_is_last    = r_ob_last;
    assign o_total_bits = r_ob_total;

`ifndef NO_ASSERTIONS
    // Queue never holds more bytes than one encode can complete
    a_ob_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ob_cnt <= OBC_W'(OB_DEPTH))
        else $error("output queue overfilled");

    // A flush result is always the only one in the queue
    a_last_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_last) |-> (r_ob_cnt == OBC_W'(1)))
        else $error("flush result shares the queue");

    // Byte results always carry data
    a_byte_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_last) |-> o_byte_valid)
        else $error("byte result without data");

    // A blocked stage 1 item stays put
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && o_stall) |=> (r_s1_valid && $stable(r_pend_cnt)))
        else $error("stage 1 item lost while blocked");

    // Stage 1 only blocks while the queue is busy
    a_block_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input blocked with empty queue");
`endif

endmodule
`default_nettype wire

@@ hdl/hcbp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire
